/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/allm_pkg.sv */
// ----------------------------------------------------------------------------
// Adaptive LED level meter package
// Field widths, register defaults and indexes, and the control bundle of the
// serial divider.
// ----------------------------------------------------------------------------
package allm_pkg;

	localparam int LVL_W   = 16;
	localparam int DISP_W  = 17;
	localparam int CEIL_W  = 17;
	localparam int THR_W   = 17;
	localparam int SPAN_W  = 18;
	localparam int METER_W = 5;
	localparam int QUIET_W = 3;
	localparam int MARG_W  = 8;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam int BASE_PIXELS_DEF = 20;
	localparam int BEAT_PIXELS_DEF = 5;
	localparam int DIV_W_DEF       = LVL_W + 5;

	localparam logic [METER_W-1:0] METER_MAX      = 5'd25;
	localparam logic [QUIET_W-1:0] QUIET_FOR_ZERO = 3'd4;

	localparam logic [MARG_W-1:0]  FLOOR_MARGIN_RST   = 8'd6;
	localparam logic [MARG_W-1:0]  GATE_MARGIN_RST    = 8'd10;
	localparam logic [MARG_W-1:0]  DISPLAY_MARGIN_RST = 8'd18;
	localparam logic [LVL_W-1:0]   MINIMUM_SPAN_RST   = 16'd180;
	localparam logic [LVL_W-1:0]   HEADROOM_EXTRA_RST = 16'd140;
	localparam logic [LVL_W-1:0]   BEAT_MARGIN_RST    = 16'd18;
	localparam logic [LVL_W-1:0]   BEAT_SPAN_RST      = 16'd140;
	localparam logic [METER_W-1:0] RELEASE_STEP_RST   = 5'd2;

	typedef enum logic [2:0] {
		REG_FLOOR_MARGIN   = 3'd0,
		REG_GATE_MARGIN    = 3'd1,
		REG_DISPLAY_MARGIN = 3'd2,
		REG_MINIMUM_SPAN   = 3'd3,
		REG_HEADROOM_EXTRA = 3'd4,
		REG_BEAT_MARGIN    = 3'd5,
		REG_BEAT_SPAN      = 3'd6,
		REG_RELEASE_STEP   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage

/* sv/allm_serdiv.sv */
// ----------------------------------------------------------------------------
// Serial restoring divider
// Shifts the dividend in one bit per cycle while step is high and shifts one quotient bit back.
// ----------------------------------------------------------------------------
module allm_serdiv #(
	parameter int NUM_W = allm_pkg::DIV_W_DEF,
	parameter int DEN_W = allm_pkg::SPAN_W
) (
	input  logic                clk,
	input  allm_pkg::div_ctrl_t ctrl,
	input  logic [NUM_W-1:0]    dividend,
	input  logic [DEN_W-1:0]    divisor,
	output logic [NUM_W-1:0]    quotient
);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (ctrl.step) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign quotient = num_q;

endmodule

/* sv/adaptive_led_level_meter_core.sv */
// Sequence: IDLE takes the block, then AVG, LVL, GATE and CTL; a gated block goes
// straight to DONE, any other block on through NORM, LOAD, DIV and TGT to DONE.
// Flow: a new block is held off by level_stall until the sequencer is back in IDLE,
// and DONE waits while the result register is not free; the serial divider, one quotient
// bit per cycle over DIV_W = 16 + bits of the pixel count, is the longest step.
// Reset: arst_n clears averages, floor, ceiling, counters and meter; registers go to defaults.
// ----------------------------------------------------------------------------
// Adaptive LED level meter core
// Tracks fast and slow block levels, an adaptive floor and ceiling, and maps
// them onto an LED bar with instant attack and stepped release.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adaptive_led_level_meter_core #(
	parameter int BASE_PIXELS = allm_pkg::BASE_PIXELS_DEF,
	parameter int BEAT_PIXELS = allm_pkg::BEAT_PIXELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [allm_pkg::ADDR_W-1:0]    paddr,
	input  logic [allm_pkg::DATA_W-1:0]    pwdata,
	output logic [allm_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           level_valid,
	output logic                           level_stall,
	input  logic [allm_pkg::LVL_W-1:0]     block_level,
	output logic                           meter_valid,
	input  logic                           meter_stall,
	output logic [allm_pkg::METER_W-1:0]   meter_pixels,
	output logic [allm_pkg::DISP_W-1:0]    display_level,
	output logic [allm_pkg::LVL_W-1:0]     floor_level,
	output logic [allm_pkg::CEIL_W-1:0]    ceiling_level,
	output logic                           gated
);
	import allm_pkg::*;

	localparam int PIX_MAX = (BASE_PIXELS > BEAT_PIXELS) ? BASE_PIXELS : BEAT_PIXELS;
	localparam int PIX_W   = $clog2(PIX_MAX + 1);
	localparam int DIV_W   = LVL_W + PIX_W;
	localparam int CNT_W   = $clog2(DIV_W);
	localparam int SUM_W   = PIX_W + METER_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_LVL,
		ST_GATE,
		ST_CTL,
		ST_NORM,
		ST_LOAD,
		ST_DIV,
		ST_TGT,
		ST_DONE
	} state_t;

	function automatic logic [LVL_W-1:0] track(
		input logic [LVL_W-1:0] avg,
		input logic [LVL_W-1:0] x,
		input logic [2:0]       up_sh,
		input logic [2:0]       dn_sh
	);
		logic [2:0]       sh;
		logic [LVL_W+4:0] acc;
		sh  = (x > avg) ? up_sh : dn_sh;
		acc = ({5'b0, avg} << sh) - {5'b0, avg} + {5'b0, x};
		acc = acc >> sh;
		return (avg == '0) ? x : acc[LVL_W-1:0];
	endfunction

	function automatic logic [METER_W-1:0] fall(
		input logic [METER_W-1:0] lit,
		input logic [METER_W-1:0] step
	);
		return (lit > step) ? (lit - step) : '0;
	endfunction

	// Configuration registers
	logic [MARG_W-1:0]  floor_margin_q;
	logic [MARG_W-1:0]  gate_margin_q;
	logic [MARG_W-1:0]  display_margin_q;
	logic [LVL_W-1:0]   minimum_span_q;
	logic [LVL_W-1:0]   headroom_extra_q;
	logic [LVL_W-1:0]   beat_margin_q;
	logic [LVL_W-1:0]   beat_span_q;
	logic [METER_W-1:0] release_step_q;
	logic               cfg_we;
	reg_idx_t           cfg_idx;

	// Sequencer and datapath state
	state_t             state_q;
	logic [CNT_W-1:0]   div_cnt_q;
	logic [LVL_W-1:0]   x_q;
	logic [LVL_W-1:0]   fast_q;
	logic [LVL_W-1:0]   slow_q;
	logic [LVL_W-1:0]   nf_q;
	logic [CEIL_W-1:0]  ceil_q;
	logic [QUIET_W-1:0] quiet_q;
	logic [METER_W-1:0] lit_q;
	logic [LVL_W-1:0]   transient_q;
	logic [DISP_W-1:0]  display_q;
	logic [THR_W-1:0]   gate_q;
	logic [THR_W-1:0]   disp_thr_q;
	logic               gated_q;
	logic [SPAN_W-1:0]  span_q;
	logic [LVL_W-1:0]   norm_base_q;
	logic [LVL_W-1:0]   norm_beat_q;

	logic               meter_valid_q;
	logic [METER_W-1:0] meter_pixels_q;
	logic [DISP_W-1:0]  display_level_q;
	logic [LVL_W-1:0]   floor_level_q;
	logic [CEIL_W-1:0]  ceiling_level_q;
	logic               gated_out_q;

	// Combinational helpers
	logic [LVL_W-1:0]   fast_new;
	logic [LVL_W-1:0]   slow_new;
	logic [LVL_W-1:0]   transient_c;
	logic [LVL_W+3:0]   nf_down_acc;
	logic [LVL_W+7:0]   nf_up_acc;
	logic [LVL_W-1:0]   nf_new;
	logic [CEIL_W+2:0]  ceil_up_acc;
	logic [CEIL_W+4:0]  ceil_dn_acc;
	logic [CEIL_W-1:0]  ceil_new;
	logic [THR_W-1:0]   gate_c;
	logic [THR_W-1:0]   disp_thr_c;
	logic [CEIL_W+2:0]  ceil_pull_acc;
	logic [QUIET_W-1:0] quiet_next;
	logic [SPAN_W-1:0]  span_raw;
	logic [SPAN_W-1:0]  span_c;
	logic [LVL_W-1:0]   beat_diff;
	logic [LVL_W-1:0]   norm_beat_c;
	logic [THR_W-1:0]   base_diff;
	logic [LVL_W-1:0]   norm_base_c;
	div_ctrl_t          div_ctrl;
	logic [DIV_W-1:0]   base_dividend;
	logic [DIV_W-1:0]   beat_dividend;
	logic [DIV_W-1:0]   base_quot;
	logic [DIV_W-1:0]   beat_quot;
	logic [PIX_W-1:0]   base_pix;
	logic [PIX_W-1:0]   beat_pix;
	logic [SUM_W-1:0]   pix_sum;
	logic [METER_W-1:0] target_c;
	logic [METER_W-1:0] lit_fall;
	logic               out_free;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_margin_q   <= FLOOR_MARGIN_RST;
			gate_margin_q    <= GATE_MARGIN_RST;
			display_margin_q <= DISPLAY_MARGIN_RST;
			minimum_span_q   <= MINIMUM_SPAN_RST;
			headroom_extra_q <= HEADROOM_EXTRA_RST;
			beat_margin_q    <= BEAT_MARGIN_RST;
			beat_span_q      <= BEAT_SPAN_RST;
			release_step_q   <= RELEASE_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FLOOR_MARGIN:   floor_margin_q   <= pwdata[MARG_W-1:0];
				REG_GATE_MARGIN:    gate_margin_q    <= pwdata[MARG_W-1:0];
				REG_DISPLAY_MARGIN: display_margin_q <= pwdata[MARG_W-1:0];
				REG_MINIMUM_SPAN:   minimum_span_q   <= pwdata[LVL_W-1:0];
				REG_HEADROOM_EXTRA: headroom_extra_q <= pwdata[LVL_W-1:0];
				REG_BEAT_MARGIN:    beat_margin_q    <= pwdata[LVL_W-1:0];
				REG_BEAT_SPAN:      beat_span_q      <= pwdata[LVL_W-1:0];
				REG_RELEASE_STEP:   release_step_q   <= pwdata[METER_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_FLOOR_MARGIN:   prdata = DATA_W'(floor_margin_q);
			REG_GATE_MARGIN:    prdata = DATA_W'(gate_margin_q);
			REG_DISPLAY_MARGIN: prdata = DATA_W'(display_margin_q);
			REG_MINIMUM_SPAN:   prdata = DATA_W'(minimum_span_q);
			REG_HEADROOM_EXTRA: prdata = DATA_W'(headroom_extra_q);
			REG_BEAT_MARGIN:    prdata = DATA_W'(beat_margin_q);
			REG_BEAT_SPAN:      prdata = DATA_W'(beat_span_q);
			REG_RELEASE_STEP:   prdata = DATA_W'(release_step_q);
		endcase
	end

	// Level tracking
	assign fast_new    = track(fast_q, x_q, 3'd2, 3'd3);
	assign slow_new    = track(slow_q, x_q, 3'd3, 3'd4);
	assign transient_c = (fast_q > slow_q) ? (fast_q - slow_q) : '0;

	assign nf_down_acc = {1'b0, nf_q, 3'b0} - {4'b0, nf_q} + {4'b0, slow_q};
	assign nf_up_acc   = {1'b0, nf_q, 7'b0} - {8'b0, nf_q} + {8'b0, slow_q};
	always_comb begin
		priority if (nf_q == '0)
			nf_new = slow_q;
		else if (slow_q < nf_q)
			nf_new = nf_down_acc[LVL_W+2:3];
		else
			nf_new = nf_up_acc[LVL_W+6:7];
	end

	assign ceil_up_acc = {1'b0, ceil_q, 2'b0} - {3'b0, ceil_q} + (CEIL_W+3)'(slow_q);
	assign ceil_dn_acc = {1'b0, ceil_q, 4'b0} - {5'b0, ceil_q} + (CEIL_W+5)'(slow_q);
	assign ceil_new    = ({1'b0, slow_q} > ceil_q) ? ceil_up_acc[CEIL_W+1:2]
	                                               : ceil_dn_acc[CEIL_W+3:4];

	// Thresholds
	assign gate_c     = {1'b0, nf_q} + THR_W'(floor_margin_q) + THR_W'(gate_margin_q);
	assign disp_thr_c = gate_c + THR_W'(display_margin_q);

	// Gated path
	assign ceil_pull_acc = {1'b0, ceil_q, 2'b0} - {3'b0, ceil_q} + {3'b0, gate_q};
	assign quiet_next    = (quiet_q < QUIET_FOR_ZERO) ? (quiet_q + 3'd1) : quiet_q;
	assign lit_fall      = fall(lit_q, release_step_q);

	// Span and normalized levels
	assign span_raw = SPAN_W'(ceil_q - disp_thr_q) + SPAN_W'(headroom_extra_q);
	always_comb begin
		if (ceil_q > disp_thr_q)
			span_c = (span_raw < SPAN_W'(minimum_span_q)) ? SPAN_W'(minimum_span_q) : span_raw;
		else
			span_c = SPAN_W'(minimum_span_q);
	end

	assign beat_diff   = transient_q - beat_margin_q;
	assign norm_beat_c = (transient_q > beat_margin_q) ?
	                     ((beat_diff > beat_span_q) ? beat_span_q : beat_diff) : '0;

	assign base_diff   = {1'b0, slow_q} - disp_thr_q;
	assign norm_base_c = ({1'b0, slow_q} > disp_thr_q) ?
	                     ((SPAN_W'(base_diff) > span_q) ? span_q[LVL_W-1:0]
	                                                    : base_diff[LVL_W-1:0]) : '0;

	// Serial dividers
	assign div_ctrl.load  = (state_q == ST_LOAD);
	assign div_ctrl.step  = (state_q == ST_DIV);
	assign base_dividend  = DIV_W'(norm_base_q) * DIV_W'(BASE_PIXELS);
	assign beat_dividend  = DIV_W'(norm_beat_q) * DIV_W'(BEAT_PIXELS);

	allm_serdiv #(
		.NUM_W (DIV_W),
		.DEN_W (SPAN_W)
	) u_base_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.dividend (base_dividend),
		.divisor  (span_q),
		.quotient (base_quot)
	);

	allm_serdiv #(
		.NUM_W (DIV_W),
		.DEN_W (LVL_W)
	) u_beat_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.dividend (beat_dividend),
		.divisor  (beat_span_q),
		.quotient (beat_quot)
	);

	// Target pixels
	always_comb begin
		base_pix = (span_q == '0) ? '0 : base_quot[PIX_W-1:0];
		if (base_pix <= PIX_W'(1))
			base_pix = '0;
		beat_pix = (beat_span_q == '0) ? '0 : beat_quot[PIX_W-1:0];
		pix_sum  = SUM_W'(base_pix) + SUM_W'(beat_pix);
		target_c = (pix_sum > SUM_W'(METER_MAX)) ? METER_MAX : pix_sum[METER_W-1:0];
	end

	assign out_free = !meter_valid_q || !meter_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			div_cnt_q       <= '0;
			x_q             <= '0;
			fast_q          <= '0;
			slow_q          <= '0;
			nf_q            <= '0;
			ceil_q          <= '0;
			quiet_q         <= '0;
			lit_q           <= '0;
			transient_q     <= '0;
			display_q       <= '0;
			gate_q          <= '0;
			disp_thr_q      <= '0;
			gated_q         <= 1'b0;
			span_q          <= '0;
			norm_base_q     <= '0;
			norm_beat_q     <= '0;
			meter_valid_q   <= 1'b0;
			meter_pixels_q  <= '0;
			display_level_q <= '0;
			floor_level_q   <= '0;
			ceiling_level_q <= '0;
			gated_out_q     <= 1'b0;
		end else begin
			if (meter_valid_q && !meter_stall && state_q != ST_DONE)
				meter_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (level_valid) begin
						x_q     <= block_level;
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					fast_q  <= fast_new;
					slow_q  <= slow_new;
					state_q <= ST_LVL;
				end
				ST_LVL: begin
					transient_q <= transient_c;
					display_q   <= {1'b0, slow_q} + {3'b0, transient_c[LVL_W-1:2]};
					nf_q        <= nf_new;
					ceil_q      <= ceil_new;
					state_q     <= ST_GATE;
				end
				ST_GATE: begin
					gate_q     <= gate_c;
					disp_thr_q <= disp_thr_c;
					gated_q    <= ({1'b0, slow_q} <= gate_c);
					state_q    <= ST_CTL;
				end
				ST_CTL: begin
					if (gated_q) begin
						quiet_q <= quiet_next;
						if (ceil_q > gate_q)
							ceil_q <= ceil_pull_acc[CEIL_W+1:2];
						lit_q   <= (quiet_next >= QUIET_FOR_ZERO) ? '0 : lit_fall;
						state_q <= ST_DONE;
					end else begin
						quiet_q     <= '0;
						span_q      <= span_c;
						norm_beat_q <= norm_beat_c;
						state_q     <= ST_NORM;
					end
				end
				ST_NORM: begin
					norm_base_q <= norm_base_c;
					state_q     <= ST_LOAD;
				end
				ST_LOAD: begin
					div_cnt_q <= CNT_W'(DIV_W - 1);
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - CNT_W'(1);
					if (div_cnt_q == '0)
						state_q <= ST_TGT;
				end
				ST_TGT: begin
					if (target_c >= lit_q)
						lit_q <= target_c;
					else
						lit_q <= (lit_fall > target_c) ? lit_fall : target_c;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						meter_valid_q   <= 1'b1;
						meter_pixels_q  <= lit_q;
						display_level_q <= display_q;
						floor_level_q   <= nf_q;
						ceiling_level_q <= ceil_q;
						gated_out_q     <= gated_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign level_stall   = (state_q != ST_IDLE);
	assign meter_valid   = meter_valid_q;
	assign meter_pixels  = meter_pixels_q;
	assign display_level = display_level_q;
	assign floor_level   = floor_level_q;
	assign ceiling_level = ceiling_level_q;
	assign gated         = gated_out_q;

	`ASSERT_IMP(a_pixels_full_scale, meter_valid_q, meter_pixels_q <= METER_MAX, "meter above full scale")
	`ASSERT_NXT(a_quiet_forces_zero, state_q == ST_CTL && gated_q && quiet_q >= QUIET_FOR_ZERO - 3'd1, lit_q == '0, "quiet run did not clear meter")
	`ASSERT_NXT(a_instant_attack, state_q == ST_TGT, lit_q >= $past(target_c), "meter below target")
	`ASSERT_NXT(a_result_waits, state_q == ST_DONE && meter_valid_q && meter_stall, state_q == ST_DONE && meter_valid_q, "result overran pending transaction")

endmodule
